// File: hw/rtl/lbs_pkg.sv
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int JOINT_SLOTS_DEF = 64;
  localparam int MAT_WORDS       = 12;
  localparam int ONE_Q16         = 65536;

  // Shared divider: 64-bit dividend, 32-bit divisor, 64-bit quotient.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;

  // Shared square root: 64-bit radicand, 32-bit root.
  localparam int SQ_IN_W   = 64;
  localparam int SQ_ROOT_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CADDR,
    ST_CMUL,
    ST_CACC,
    ST_TMUL,
    ST_TACC,
    ST_WMUL,
    ST_WACC,
    ST_FIN0,
    ST_PPOS,
    ST_PDIV,
    ST_NPREP,
    ST_NSHIFT,
    ST_LMUL,
    ST_LACC,
    ST_SQ0,
    ST_SQW,
    ST_NDIV0,
    ST_NDIVW,
    ST_OUT
  } lbs_state_t;

endpackage

// File: hw/rtl/linear_blend_skinning_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    operation, slot, word, position, normal, weight
// out_     output     out_valid / out_stall  skinned position, unit normal, zero flag
// cfg_     input      cfg_wr_en              weight epsilon (16 bit)
//
// A load beat writes one matrix word and leaves the sequencer idle. A contribution
// beat whose matrix is present uses one shared 32x32 multiplier, which does 60
// products fed by the two read ports of the matrix memory. The last beat of a vertex
// then runs the bit-serial divider (up to six divisions) and the square root. Reset
// is synchronous and active low; the matrix memory is not cleared. A finished result
// waits in the output register while the next beats are taken; only a new result
// waits for out_stall to release that register.
module linear_blend_skinning_top #(
  parameter int JOINT_SLOTS = lbs_pkg::JOINT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [6:0]         in_slot,
  input  logic [3:0]         in_word_select,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [17:0] in_nrm_x,
  input  logic signed [17:0] in_nrm_y,
  input  logic signed [17:0] in_nrm_z,
  input  logic [16:0]        in_weight,
  input  logic               in_matrix_present,
  input  logic               in_last_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [17:0] out_nrm_x,
  output logic signed [17:0] out_nrm_y,
  output logic signed [17:0] out_nrm_z,
  output logic               out_zero_total,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int DEPTH = (JOINT_SLOTS + 1) * lbs_pkg::MAT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] OBJ_BASE = AW'(JOINT_SLOTS * lbs_pkg::MAT_WORDS);

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -51'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    else if (v < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    else return v[47:0];
  endfunction

  // The matrix table: joint slots followed by the object transform, twelve words each.
  logic signed [31:0] mem [DEPTH];

  lbs_pkg::lbs_state_t state_r, state_nxt;

  logic [15:0]        eps_r;
  logic [AW-1:0]      jbase_r;
  logic signed [31:0] p_r [3];
  logic signed [17:0] n_r [3];
  logic [16:0]        w_r;
  logic               last_r;

  logic [1:0]         row_r, col_r, k_r;
  logic [2:0]         t_r;
  logic               u_r;

  logic signed [31:0] rd_a_r, rd_b_r;
  logic signed [63:0] mul_r;
  logic signed [50:0] s_r, tp_r, tn_r;
  logic signed [31:0] c_row_r [4];

  logic signed [47:0] pos_acc_r [3];
  logic signed [47:0] nrm_acc_r [3];
  logic [31:0]        ws_r;

  logic               scale_r;
  logic [47:0]        nm_r [3];
  logic [61:0]        len2_r;
  logic [31:0]        len_r;

  logic signed [31:0] res_pos_r [3];
  logic signed [17:0] res_nrm_r [3];
  logic               res_zero_r;

  logic               out_valid_r;
  logic signed [31:0] out_pos_r [3];
  logic signed [17:0] out_nrm_r [3];
  logic               out_zero_r;

  // Control from the sequencer.
  logic               accept;
  logic               slot_ok;
  logic [31:0]        jbase_full;
  logic [AW-1:0]      jbase;
  logic [AW-1:0]      addr_a, addr_b;
  logic               mem_we;
  logic signed [31:0] mul_a, mul_b;
  logic               div_start, sq_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic               div_done, sq_done;
  logic [63:0]        div_q;
  logic [31:0]        sq_root;
  logic               out_free;

  logic signed [47:0] prod_q;
  logic [1:0]         tk;
  logic signed [31:0] c_val;
  logic signed [47:0] acc_sel;
  logic [47:0]        acc_mag;
  logic [32:0]        ws_sum;
  logic [32:0]        wdiff;
  logic [47:0]        nm_or;

  assign accept     = in_valid && !in_stall;
  assign jbase_full = 32'(in_slot) * 32'd12;
  assign jbase      = jbase_full[AW-1:0];
  assign slot_ok    = 32'(in_slot) <= 32'(JOINT_SLOTS);
  assign out_free   = !out_valid_r || !out_stall;

  // The product is taken back to Q16.16 by an arithmetic shift (floor).
  assign prod_q  = mul_r[63:16];
  assign tk      = (t_r < 3'd3) ? t_r[1:0] : 2'(t_r - 3'd3);
  assign c_val   = sat32(s_r + ((col_r == 2'd3) ? 51'(rd_a_r) : 51'sd0));
  assign acc_sel = pos_acc_r[row_r];
  assign acc_mag = acc_sel[47] ? 48'(-acc_sel) : 48'(acc_sel);
  assign ws_sum  = 33'(ws_r) + 33'(w_r);
  assign wdiff   = (ws_r >= 32'(lbs_pkg::ONE_Q16)) ? 33'(ws_r) - 33'(lbs_pkg::ONE_Q16)
                                                   : 33'(lbs_pkg::ONE_Q16) - 33'(ws_r);
  assign nm_or   = nm_r[0] | nm_r[1] | nm_r[2];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbs_pkg::ST_IDLE: begin
        if (accept && in_operation) begin
          if (in_matrix_present && slot_ok) state_nxt = lbs_pkg::ST_CADDR;
          else if (in_last_weight) state_nxt = lbs_pkg::ST_FIN0;
        end
      end
      lbs_pkg::ST_CADDR: state_nxt = lbs_pkg::ST_CMUL;
      lbs_pkg::ST_CMUL: begin
        if (k_r != 2'd3) state_nxt = lbs_pkg::ST_CACC;
        else if (col_r == 2'd3) state_nxt = lbs_pkg::ST_TMUL;
        else state_nxt = lbs_pkg::ST_CADDR;
      end
      lbs_pkg::ST_CACC: state_nxt = lbs_pkg::ST_CADDR;
      lbs_pkg::ST_TMUL: state_nxt = lbs_pkg::ST_TACC;
      lbs_pkg::ST_TACC: begin
        state_nxt = (t_r == 3'd5) ? lbs_pkg::ST_WMUL : lbs_pkg::ST_TMUL;
      end
      lbs_pkg::ST_WMUL: state_nxt = lbs_pkg::ST_WACC;
      lbs_pkg::ST_WACC: begin
        if (!u_r) state_nxt = lbs_pkg::ST_WMUL;
        else if (row_r != 2'd2) state_nxt = lbs_pkg::ST_CADDR;
        else if (last_r) state_nxt = lbs_pkg::ST_FIN0;
        else state_nxt = lbs_pkg::ST_IDLE;
      end
      lbs_pkg::ST_FIN0: begin
        state_nxt = (ws_r == '0) ? lbs_pkg::ST_OUT : lbs_pkg::ST_PPOS;
      end
      lbs_pkg::ST_PPOS: begin
        if (scale_r) state_nxt = lbs_pkg::ST_PDIV;
        else if (row_r == 2'd2) state_nxt = lbs_pkg::ST_NPREP;
      end
      lbs_pkg::ST_PDIV: begin
        if (div_done) begin
          state_nxt = (row_r == 2'd2) ? lbs_pkg::ST_NPREP : lbs_pkg::ST_PPOS;
        end
      end
      lbs_pkg::ST_NPREP: state_nxt = lbs_pkg::ST_NSHIFT;
      lbs_pkg::ST_NSHIFT: begin
        if (nm_or[47:30] == '0) state_nxt = lbs_pkg::ST_LMUL;
      end
      lbs_pkg::ST_LMUL: state_nxt = lbs_pkg::ST_LACC;
      lbs_pkg::ST_LACC: begin
        state_nxt = (row_r == 2'd2) ? lbs_pkg::ST_SQ0 : lbs_pkg::ST_LMUL;
      end
      lbs_pkg::ST_SQ0: begin
        state_nxt = (len2_r == '0) ? lbs_pkg::ST_OUT : lbs_pkg::ST_SQW;
      end
      lbs_pkg::ST_SQW: begin
        if (sq_done) state_nxt = lbs_pkg::ST_NDIV0;
      end
      lbs_pkg::ST_NDIV0: state_nxt = lbs_pkg::ST_NDIVW;
      lbs_pkg::ST_NDIVW: begin
        if (div_done) begin
          state_nxt = (row_r == 2'd2) ? lbs_pkg::ST_OUT : lbs_pkg::ST_NDIV0;
        end
      end
      lbs_pkg::ST_OUT: begin
        if (out_free) state_nxt = lbs_pkg::ST_IDLE;
      end
      default: state_nxt = lbs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory addresses, multiplier operands, unit starts.
  always_comb begin
    in_stall  = (state_r != lbs_pkg::ST_IDLE);
    mem_we    = accept && !in_operation && slot_ok && (in_word_select < 4'd12);
    addr_a    = OBJ_BASE + AW'({row_r, k_r});
    addr_b    = (k_r == 2'd3) ? jbase_r : jbase_r + AW'({k_r, col_r});
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    div_num   = {16'b0, acc_mag};
    div_num   = div_num << 16;
    div_den   = ws_r;
    if (mem_we) addr_a = jbase + AW'(in_word_select);
    case (state_r)
      lbs_pkg::ST_CMUL: begin
        mul_a = rd_a_r;
        mul_b = rd_b_r;
      end
      lbs_pkg::ST_TMUL: begin
        mul_a = c_row_r[tk];
        mul_b = (t_r < 3'd3) ? p_r[tk] : 32'(n_r[tk]);
      end
      lbs_pkg::ST_WMUL: begin
        mul_a = u_r ? sat32(tn_r) : sat32(tp_r);
        mul_b = $signed({15'b0, w_r});
      end
      lbs_pkg::ST_LMUL: begin
        mul_a = $signed({2'b0, nm_r[row_r][29:0]});
        mul_b = $signed({2'b0, nm_r[row_r][29:0]});
      end
      lbs_pkg::ST_PPOS: div_start = scale_r;
      lbs_pkg::ST_SQ0: sq_start = (len2_r != '0);
      lbs_pkg::ST_NDIV0: begin
        div_start = 1'b1;
        div_num   = {18'b0, nm_r[row_r][29:0], 16'b0};
        div_den   = len_r;
      end
      default: begin
      end
    endcase
  end

  // Matrix memory: one write port shared with read port A, registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_a] <= in_pos_x;
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  lbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  lbs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({2'b0, len2_r}),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbs_pkg::ST_IDLE;
      eps_r       <= 16'd1;
      out_valid_r <= 1'b0;
      ws_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_acc_r[i] <= '0;
        nrm_acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) eps_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        lbs_pkg::ST_WACC: begin
          if (!u_r) begin
            pos_acc_r[row_r] <= sat48(49'(pos_acc_r[row_r]) + 49'(prod_q));
          end else begin
            nrm_acc_r[row_r] <= sat48(49'(nrm_acc_r[row_r]) + 49'(prod_q));
            if (row_r == 2'd2) ws_r <= ws_sum[32] ? '1 : ws_sum[31:0];
          end
        end
        lbs_pkg::ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            ws_r        <= '0;
            for (int i = 0; i < 3; i++) begin
              pos_acc_r[i] <= '0;
              nrm_acc_r[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers and counters.
  always_ff @(posedge clk) begin
    case (state_r)
      lbs_pkg::ST_IDLE: begin
        if (accept) begin
          jbase_r <= jbase;
          p_r[0]  <= in_pos_x;
          p_r[1]  <= in_pos_y;
          p_r[2]  <= in_pos_z;
          n_r[0]  <= in_nrm_x;
          n_r[1]  <= in_nrm_y;
          n_r[2]  <= in_nrm_z;
          w_r     <= in_weight;
          last_r  <= in_last_weight;
          row_r   <= '0;
          col_r   <= '0;
          k_r     <= '0;
          s_r     <= '0;
        end
      end
      lbs_pkg::ST_CMUL: begin
        if (k_r == 2'd3) begin
          c_row_r[col_r] <= c_val;
          s_r            <= '0;
          k_r            <= '0;
          col_r          <= col_r + 1'b1;
          if (col_r == 2'd3) begin
            tp_r <= 51'(c_val);
            tn_r <= '0;
            t_r  <= '0;
          end
        end
      end
      lbs_pkg::ST_CACC: begin
        s_r <= s_r + 51'(prod_q);
        k_r <= k_r + 1'b1;
      end
      lbs_pkg::ST_TACC: begin
        if (t_r < 3'd3) tp_r <= tp_r + 51'(prod_q);
        else tn_r <= tn_r + 51'(prod_q);
        t_r <= t_r + 1'b1;
        u_r <= 1'b0;
      end
      lbs_pkg::ST_WACC: begin
        u_r <= 1'b1;
        if (u_r) row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 1'b1;
      end
      lbs_pkg::ST_FIN0: begin
        row_r      <= '0;
        scale_r    <= wdiff > 33'(eps_r);
        res_zero_r <= (ws_r == '0);
        for (int i = 0; i < 3; i++) begin
          res_pos_r[i] <= '0;
          res_nrm_r[i] <= '0;
        end
      end
      lbs_pkg::ST_PPOS: begin
        if (!scale_r) begin
          res_pos_r[row_r] <= sat32(51'(acc_sel));
          row_r            <= row_r + 1'b1;
        end
      end
      lbs_pkg::ST_PDIV: begin
        if (div_done) begin
          if (acc_sel[47]) begin
            res_pos_r[row_r] <= (div_q > 64'h8000_0000) ? 32'sh80000000
                                                         : 32'(-div_q[31:0]);
          end else begin
            res_pos_r[row_r] <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF
                                                         : $signed(div_q[31:0]);
          end
          row_r <= row_r + 1'b1;
        end
      end
      lbs_pkg::ST_NPREP: begin
        for (int i = 0; i < 3; i++) begin
          nm_r[i] <= nrm_acc_r[i][47] ? 48'(-nrm_acc_r[i]) : 48'(nrm_acc_r[i]);
        end
      end
      lbs_pkg::ST_NSHIFT: begin
        // Drop low bits until every magnitude is below 2^30.
        if (nm_or[47:30] != '0) begin
          for (int i = 0; i < 3; i++) nm_r[i] <= nm_r[i] >> 1;
        end
        row_r  <= '0;
        len2_r <= '0;
      end
      lbs_pkg::ST_LACC: begin
        len2_r <= len2_r + mul_r[61:0];
        row_r  <= (row_r == 2'd2) ? 2'd0 : row_r + 1'b1;
      end
      lbs_pkg::ST_SQW: begin
        if (sq_done) len_r <= sq_root;
      end
      lbs_pkg::ST_NDIVW: begin
        if (div_done) begin
          res_nrm_r[row_r] <= nrm_acc_r[row_r][47] ? 18'(-div_q[17:0])
                                                   : $signed(div_q[17:0]);
          row_r <= row_r + 1'b1;
        end
      end
      lbs_pkg::ST_OUT: begin
        if (out_free) begin
          out_zero_r <= res_zero_r;
          for (int i = 0; i < 3; i++) begin
            out_pos_r[i] <= res_pos_r[i];
            out_nrm_r[i] <= res_nrm_r[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pos_r[0];
  assign out_pos_y      = out_pos_r[1];
  assign out_pos_z      = out_pos_r[2];
  assign out_nrm_x      = out_nrm_r[0];
  assign out_nrm_y      = out_nrm_r[1];
  assign out_nrm_z      = out_nrm_r[2];
  assign out_zero_total = out_zero_r;

  // A new result beat only ever comes out of the output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == lbs_pkg::ST_OUT))
    else $error("result beat raised outside the output state");

  // A zero weight sum gives all-zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_total) |->
      (out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0 &&
       out_nrm_x == 0 && out_nrm_y == 0 && out_nrm_z == 0))
    else $error("zero weight sum with nonzero result fields");

  // A unit normal component never exceeds one.
  a_nrm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbs_pkg::ST_NDIVW && div_done) |-> (div_q <= 64'd65536))
    else $error("normal component quotient above one");

  // The sequencer never takes a beat outside the idle state, so not while the accumulators are being cleared.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lbs_pkg::ST_IDLE) |-> in_stall)
    else $error("input beat possible while the sequencer is busy");

endmodule

// File: hw/rtl/lbs_div.sv
`timescale 1ns / 1ps

module lbs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lbs_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [lbs_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                            done,
  output logic [lbs_pkg::DIV_NUM_W-1:0]   quotient
);

  localparam int CW = $clog2(lbs_pkg::DIV_NUM_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [lbs_pkg::DIV_DEN_W-1:0] rem_r;
  logic [lbs_pkg::DIV_NUM_W-1:0] quo_r;
  logic [lbs_pkg::DIV_DEN_W-1:0] den_r;
  logic [lbs_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          take;

  // One restoring step per cycle, most significant dividend bit first.
  assign rem_sh = {rem_r, quo_r[lbs_pkg::DIV_NUM_W-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(lbs_pkg::DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? lbs_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                    : rem_sh[lbs_pkg::DIV_DEN_W-1:0];
      quo_r <= {quo_r[lbs_pkg::DIV_NUM_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/lbs_sqrt.sv
`timescale 1ns / 1ps

module lbs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lbs_pkg::SQ_IN_W-1:0]   radicand,
  output logic                          done,
  output logic [lbs_pkg::SQ_ROOT_W-1:0] root
);

  localparam int CW = $clog2(lbs_pkg::SQ_ROOT_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [lbs_pkg::SQ_IN_W-1:0] x_r;
  logic [lbs_pkg::SQ_IN_W-1:0] r_r;
  logic [lbs_pkg::SQ_IN_W-1:0] bit_r;
  logic [lbs_pkg::SQ_IN_W-1:0] trial;

  // Digit-by-digit floor square root, one result bit per cycle.
  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(lbs_pkg::SQ_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      r_r   <= '0;
      bit_r <= {2'b01, {(lbs_pkg::SQ_IN_W-2){1'b0}}};
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[lbs_pkg::SQ_ROOT_W-1:0];

endmodule
